[rtl/bfrfl_pkg.sv]
// shared codes and types for the best-fit range free list
package bfrfl_pkg;

  typedef logic [2:0] status_t;

  localparam status_t STATUS_ALLOCATED     = 3'd0;
  localparam status_t STATUS_NO_FIT        = 3'd1;
  localparam status_t STATUS_MERGED_AFTER  = 3'd2;
  localparam status_t STATUS_MERGED_BEFORE = 3'd3;
  localparam status_t STATUS_NEW_ENTRY     = 3'd4;
  localparam status_t STATUS_DROPPED_FULL  = 3'd5;

  localparam logic FUNC_FREE  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

endpackage

[rtl/bfrfl_ifs.sv]
// request and response channel interfaces
interface bfrfl_req_if #(
  parameter int PAGE_BITS = 35
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [PAGE_BITS-1:0] base_page;
  logic [PAGE_BITS:0]   length_pages;

  modport source (output valid, func, base_page, length_pages, input ready);
  modport sink (input valid, func, base_page, length_pages, output ready);
endinterface

interface bfrfl_rsp_if
  import bfrfl_pkg::*;
#(
  parameter int PAGE_BITS = 35,
  parameter int CNT_W     = 7
);
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [PAGE_BITS-1:0] granted_page;
  status_t              status;
  logic [CNT_W-1:0]     entries_used;

  modport source (output valid, found, granted_page, status, entries_used, input ready);
  modport sink (input valid, found, granted_page, status, entries_used, output ready);
endinterface

[rtl/bfrfl_cell.sv]
// one slot of the rotating range ring
module bfrfl_cell #(
  parameter int PAGE_BITS = 35
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic [PAGE_BITS-1:0] base_in,
  input  logic [PAGE_BITS:0]   len_in,
  output logic [PAGE_BITS-1:0] base,
  output logic [PAGE_BITS:0]   len
);

  always_ff @(posedge clk) begin
    if (shift) begin
      base <= base_in;
      len  <= len_in;
    end
  end

endmodule

[rtl/best_fit_range_free_list.sv]
// best-fit free list of page ranges with coalescing, built as a rotating ring of cells
//
//   channel  dir  handshake      payload
//   req      in   valid / ready  func, base_page, length_pages
//   rsp      out  valid / ready  found, granted_page, status, entries_used
//
// one item at a time; every pass turns the ring once, past every slot
// free without neighbor or full table: 1 to 2 passes; alloc: 1 to 3 passes;
// free with a double merge: 4 passes
// req.ready is high only while idle; a result waits in the rsp register
// rst is synchronous and empties the list; slot contents are never cleared
module best_fit_range_free_list
  import bfrfl_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int PAGE_BITS = 35
) (
  input logic clk,
  input logic rst,
  bfrfl_req_if.sink   req,
  bfrfl_rsp_if.source rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LEN_W = PAGE_BITS + 1;
  localparam int SUM_W = PAGE_BITS + 2;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ENTRIES - 1);

  // controller state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1; // find neighbor or best fit
  localparam logic [2:0] S_SCAN2 = 3'd2; // write primary, find second neighbor
  localparam logic [2:0] S_WRITE = 3'd3; // write final entry, capture last live entry
  localparam logic [2:0] S_DROP  = 3'd4; // refill the emptied slot with the last entry
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state;
  logic [IDX_W-1:0]     pos;       // slot index sitting in the head cell
  logic [CNT_W-1:0]     live;
  logic                 shift;

  // ring of cells; cell 0 is the head where all decisions are made
  logic [PAGE_BITS-1:0] cell_base [ENTRIES];
  logic [LEN_W-1:0]     cell_len  [ENTRIES];
  logic [PAGE_BITS-1:0] head_base_next;
  logic [LEN_W-1:0]     head_len_next;

  // latched request
  logic                 r_func;
  logic [PAGE_BITS-1:0] r_base;
  logic [LEN_W-1:0]     r_len;

  // primary hit (free neighbor or alloc best fit)
  logic                 have;
  logic                 stop;
  logic                 p_after;
  logic [IDX_W-1:0]     p_idx;
  logic [PAGE_BITS-1:0] p_base;
  logic [LEN_W-1:0]     p_len;
  logic [PAGE_BITS-1:0] u_base;
  logic [LEN_W-1:0]     u_len;

  // second neighbor
  logic                 j_hit;
  logic [IDX_W-1:0]     j_idx;
  logic [PAGE_BITS-1:0] j_base;
  logic [LEN_W-1:0]     j_len;

  // pending write and drop
  logic                 a_en;
  logic [IDX_W-1:0]     a_idx;
  logic [PAGE_BITS-1:0] a_base;
  logic [LEN_W-1:0]     a_len;
  logic                 d_en;
  logic [IDX_W-1:0]     d_idx;
  logic [PAGE_BITS-1:0] last_base;
  logic [LEN_W-1:0]     last_len;

  logic                 res_found;
  logic [PAGE_BITS-1:0] res_grant;
  status_t              res_status;

  // head datapath
  logic                 in_live;
  logic                 pass_end;
  logic [SUM_W-1:0]     head_end;
  logic [SUM_W-1:0]     req_end;
  logic [SUM_W-1:0]     u_end;
  logic [SUM_W-1:0]     head_sum;
  logic [LEN_W-1:0]     head_sat;
  logic [SUM_W-1:0]     merge_sum;
  logic [LEN_W-1:0]     merge_sat;
  logic                 free_after;
  logic                 free_before;
  logic                 j_match;
  logic [IDX_W-1:0]     last_idx;

  // hits including the entry now at the head, so the last slot counts at pass end
  logic                 nb_take;
  logic                 nb_have;
  logic                 nb_after;
  logic                 fit_take;
  logic                 fit_have;
  logic [IDX_W-1:0]     fit_idx;
  logic [PAGE_BITS-1:0] fit_base;
  logic [LEN_W-1:0]     fit_len;
  logic                 j_take;
  logic                 j_any;
  logic [IDX_W-1:0]     j_idx_now;
  logic [PAGE_BITS-1:0] j_base_now;
  logic [LEN_W-1:0]     j_len_now;
  logic                 emit;

  assign shift    = (state == S_SCAN1) || (state == S_SCAN2) ||
                    (state == S_WRITE) || (state == S_DROP);
  assign in_live  = CNT_W'(pos) < live;
  assign pass_end = (pos == LAST_POS);
  assign last_idx = IDX_W'(live - CNT_W'(1));

  assign head_end  = SUM_W'(cell_base[0]) + SUM_W'(cell_len[0]);
  assign req_end   = SUM_W'(r_base) + SUM_W'(r_len);
  assign u_end     = SUM_W'(u_base) + SUM_W'(u_len);
  // saturating length adds: head with request, primary with second neighbor
  assign head_sum  = SUM_W'(cell_len[0]) + SUM_W'(r_len);
  assign head_sat  = head_sum[SUM_W-1] ? '1 : head_sum[LEN_W-1:0];
  assign merge_sum = SUM_W'(u_len) + SUM_W'(j_len_now);
  assign merge_sat = merge_sum[SUM_W-1] ? '1 : merge_sum[LEN_W-1:0];

  assign free_after  = head_end == SUM_W'(r_base);
  assign free_before = req_end == SUM_W'(cell_base[0]);
  assign j_match     = p_after ? (u_end == SUM_W'(cell_base[0]))
                               : (head_end == SUM_W'(u_base));

  // first abutting entry, "ends at base" tested before "starts at end"
  assign nb_take  = in_live && !have && (free_after || free_before);
  assign nb_have  = have || nb_take;
  assign nb_after = have ? p_after : free_after;

  // best fit, first on ties, stop on exact fit
  assign fit_take = in_live && !stop && cell_len[0] >= r_len &&
                    (!have || cell_len[0] < p_len);
  assign fit_have = have || fit_take;
  assign fit_idx  = fit_take ? pos : p_idx;
  assign fit_base = fit_take ? cell_base[0] : p_base;
  assign fit_len  = fit_take ? cell_len[0] : p_len;

  // second neighbor, first one in slot order other than the primary
  assign j_take     = in_live && !j_hit && pos != p_idx && j_match;
  assign j_any      = j_hit || j_take;
  assign j_idx_now  = j_hit ? j_idx : pos;
  assign j_base_now = j_hit ? j_base : cell_base[0];
  assign j_len_now  = j_hit ? j_len : cell_len[0];

  // result register takes a new item when empty or being drained
  assign emit = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // value handed from the head back to the tail cell
  always_comb begin
    head_base_next = cell_base[0];
    head_len_next  = cell_len[0];
    case (state)
      S_SCAN2: begin
        if (pos == p_idx) begin
          head_base_next = u_base;
          head_len_next  = u_len;
        end
      end
      S_WRITE: begin
        if (a_en && pos == a_idx) begin
          head_base_next = a_base;
          head_len_next  = a_len;
        end
      end
      S_DROP: begin
        if (pos == d_idx) begin
          head_base_next = last_base;
          head_len_next  = last_len;
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_ring
    if (g == ENTRIES - 1) begin : g_tail
      bfrfl_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
        .clk     (clk),
        .shift   (shift),
        .base_in (head_base_next),
        .len_in  (head_len_next),
        .base    (cell_base[g]),
        .len     (cell_len[g])
      );
    end else begin : g_body
      bfrfl_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
        .clk     (clk),
        .shift   (shift),
        .base_in (cell_base[g+1]),
        .len_in  (cell_len[g+1]),
        .base    (cell_base[g]),
        .len     (cell_len[g])
      );
    end
  end

  assign req.ready = (state == S_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      live      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (shift) begin
        pos <= pass_end ? '0 : pos + IDX_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (pass_end) begin
            if (r_func == FUNC_FREE) begin
              if (nb_have) begin
                state <= S_SCAN2;
              end else if (live < CNT_W'(ENTRIES)) begin
                live  <= live + CNT_W'(1);
                state <= S_WRITE;
              end else begin
                state <= S_DONE;
              end
            end else begin
              state <= fit_have ? S_WRITE : S_DONE;
            end
          end
        end
        S_SCAN2: begin
          if (pass_end) begin
            state <= j_any ? S_WRITE : S_DONE;
          end
        end
        S_WRITE: begin
          if (pass_end) begin
            state <= d_en ? S_DROP : S_DONE;
          end
        end
        S_DROP: begin
          if (pass_end) begin
            live  <= live - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        r_func    <= req.func;
        r_base    <= req.base_page;
        r_len     <= req.length_pages;
        have      <= 1'b0;
        stop      <= 1'b0;
        j_hit     <= 1'b0;
        a_en      <= 1'b0;
        d_en      <= 1'b0;
        res_found <= 1'b0;
        res_grant <= '0;
      end
      S_SCAN1: begin
        if (r_func == FUNC_FREE) begin
          if (nb_take) begin
            have    <= 1'b1;
            p_idx   <= pos;
            p_after <= free_after;
            u_base  <= free_after ? cell_base[0] : r_base;
            u_len   <= head_sat;
          end
        end else begin
          if (fit_take) begin
            have   <= 1'b1;
            p_idx  <= pos;
            p_base <= cell_base[0];
            p_len  <= cell_len[0];
            stop   <= (cell_len[0] == r_len);
          end
        end
        if (pass_end) begin
          if (r_func == FUNC_FREE) begin
            if (nb_have) begin
              res_status <= nb_after ? STATUS_MERGED_AFTER : STATUS_MERGED_BEFORE;
            end else if (live < CNT_W'(ENTRIES)) begin
              a_en       <= 1'b1;
              a_idx      <= IDX_W'(live);
              a_base     <= r_base;
              a_len      <= r_len;
              res_status <= STATUS_NEW_ENTRY;
            end else begin
              res_status <= STATUS_DROPPED_FULL;
            end
          end else if (fit_have) begin
            res_found  <= 1'b1;
            res_grant  <= fit_base;
            res_status <= STATUS_ALLOCATED;
            a_idx      <= fit_idx;
            d_idx      <= fit_idx;
            a_base     <= fit_base + r_len[PAGE_BITS-1:0];
            a_len      <= fit_len - r_len;
            a_en       <= (fit_len != r_len);
            d_en       <= (fit_len == r_len);
          end else begin
            res_status <= STATUS_NO_FIT;
          end
        end
      end
      S_SCAN2: begin
        if (j_take) begin
          j_hit  <= 1'b1;
          j_idx  <= pos;
          j_base <= cell_base[0];
          j_len  <= cell_len[0];
        end
        if (pass_end && j_any) begin
          a_en  <= 1'b1;
          d_en  <= 1'b1;
          a_len <= merge_sat;
          if (p_after) begin
            a_idx  <= p_idx;
            a_base <= u_base;
            d_idx  <= j_idx_now;
          end else begin
            a_idx  <= j_idx_now;
            a_base <= j_base_now;
            d_idx  <= p_idx;
          end
        end
      end
      S_WRITE: begin
        if (pos == last_idx) begin
          last_base <= head_base_next;
          last_len  <= head_len_next;
        end
      end
      S_DONE: begin
        if (emit) begin
          rsp.found        <= res_found;
          rsp.granted_page <= res_grant;
          rsp.status       <= res_status;
          rsp.entries_used <= live;
        end
      end
      default: ;
    endcase
  end

  // the list never holds more than its slots
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(ENTRIES))
    else $error("live count above table size");

  // the ring is aligned with slot zero at the head whenever idle
  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> pos == '0)
    else $error("ring not aligned while idle");

  // an accepted item starts the first scan pass
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_SCAN1)
    else $error("accepted item did not start a scan");

  // found goes with the allocated status only
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.found == (rsp.status == STATUS_ALLOCATED))
    else $error("found flag and status disagree");

endmodule
